// ===== rtl/nptd_pkg.sv =====
package nptd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS      = 16;
  localparam int QUEUE_DEPTH    = 2;
  // data words carried by one job: center x, right num/den, left num/den
  localparam int JOB_WORDS      = 5;

  typedef enum logic [1:0] {
    MODE_BOTH,
    MODE_RIGHT,
    MODE_LEFT,
    MODE_HOLD
  } mode_t;

  typedef struct packed {
    mode_t mode;
    logic  set_head;  // first result of the set: held slope counts as zero
    logic  last;
    logic  r_neg;     // sign of the right quotient
    logic  l_neg;     // sign of the left quotient
  } job_ctl_t;

endpackage

// ===== rtl/nptd_front.sv =====
module nptd_front #(
  parameter int DATA_WIDTH = nptd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                                      clk,
  input  logic                                                      rst_n,
  input  logic                                                      in_valid,
  output logic                                                      in_stall,
  input  logic signed [DATA_WIDTH-1:0]                              in_x_value,
  input  logic signed [DATA_WIDTH-1:0]                              in_y_value,
  input  logic                                                      in_first_sample,
  input  logic                                                      in_last_sample,
  input  logic                                                      q_full,
  output logic                                                      push,
  output logic [$bits(nptd_pkg::job_ctl_t)+nptd_pkg::JOB_WORDS*DATA_WIDTH-1:0] job
);
  import nptd_pkg::*;

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_TWO   = 2'd2;

  logic signed [DATA_WIDTH-1:0] wx0_r, wx1_r, wy0_r, wy1_r;
  logic [1:0]                   fill_r, fill_nxt;
  logic                         head_r, head_nxt;
  logic                         accept, restart;

  logic [DATA_WIDTH:0]   d_ry, d_rx, d_ly, d_lx;
  logic [DATA_WIDTH-1:0] m_ry, m_rx, m_ly, m_lx;
  logic                  right_ok, left_ok;
  job_ctl_t              ctl;

  function automatic logic [DATA_WIDTH:0] sub_ext(input logic [DATA_WIDTH-1:0] a,
                                                  input logic [DATA_WIDTH-1:0] b);
    return {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
  endfunction

  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH:0] d);
    return d[DATA_WIDTH] ? -d[DATA_WIDTH-1:0] : d[DATA_WIDTH-1:0];
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign restart  = in_first_sample || (fill_r == FILL_EMPTY);
  assign push     = accept && !restart && (fill_r == FILL_TWO);

  assign d_ry = sub_ext(in_y_value, wy1_r);
  assign d_rx = sub_ext(in_x_value, wx1_r);
  assign d_ly = sub_ext(wy1_r, wy0_r);
  assign d_lx = sub_ext(wx1_r, wx0_r);
  assign m_ry = mag(d_ry);
  assign m_rx = mag(d_rx);
  assign m_ly = mag(d_ly);
  assign m_lx = mag(d_lx);

  assign right_ok = (in_x_value != wx1_r);
  assign left_ok  = (wx0_r != wx1_r);

  always_comb begin
    ctl.set_head = head_r;
    ctl.last     = in_last_sample;
    ctl.r_neg    = d_ry[DATA_WIDTH] ^ d_rx[DATA_WIDTH];
    ctl.l_neg    = d_ly[DATA_WIDTH] ^ d_lx[DATA_WIDTH];
    if (right_ok && left_ok) begin
      ctl.mode = MODE_BOTH;
    end else if (right_ok) begin
      ctl.mode = MODE_RIGHT;
    end else if (left_ok) begin
      ctl.mode = MODE_LEFT;
    end else begin
      ctl.mode = MODE_HOLD;
    end
  end

  assign job = {ctl, wx1_r, m_ry, m_rx, m_ly, m_lx};

  always_comb begin
    fill_nxt = fill_r;
    head_nxt = head_r;
    if (accept) begin
      if (restart) begin
        fill_nxt = in_last_sample ? FILL_EMPTY : FILL_ONE;
        head_nxt = 1'b1;
      end else begin
        fill_nxt = in_last_sample ? FILL_EMPTY : FILL_TWO;
        if (push) begin
          head_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= FILL_EMPTY;
      head_r <= 1'b1;
    end else begin
      fill_r <= fill_nxt;
      head_r <= head_nxt;
    end
  end

  // shift the window; a restart leaves only the new sample
  always_ff @(posedge clk) begin
    if (accept) begin
      wx0_r <= restart ? '0 : wx1_r;
      wy0_r <= restart ? '0 : wy1_r;
      wx1_r <= in_x_value;
      wy1_r <= in_y_value;
    end
  end

endmodule

// ===== rtl/nptd_queue.sv =====
module nptd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  import nptd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = entry_r[rd_ptr_r];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/nptd_back.sv =====
module nptd_back #(
  parameter int DATA_WIDTH = nptd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                                      clk,
  input  logic                                                      rst_n,
  input  logic                                                      q_empty,
  input  logic [$bits(nptd_pkg::job_ctl_t)+nptd_pkg::JOB_WORDS*DATA_WIDTH-1:0] job,
  output logic                                                      pop,
  output logic                                                      out_valid,
  input  logic                                                      out_stall,
  output logic signed [DATA_WIDTH-1:0]                              out_x_center,
  output logic signed [DATA_WIDTH-1:0]                              out_slope,
  output logic                                                      out_saturated,
  output logic                                                      out_last_result
);
  import nptd_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int QW    = DATA_WIDTH + FRAC_BITS;
  localparam int STEPS = QW;
  localparam int CNTW  = $clog2(STEPS);
  localparam int CTLW  = $bits(job_ctl_t);
  localparam logic [QW-1:0] LIM_NEG = {{FRAC_BITS{1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_FIX, S_MEAN, S_DONE} state_t;

  state_t          state_r, state_nxt;
  job_ctl_t        ctl_r, ctl_nxt, job_ctl;
  logic [W-1:0]    xc_r, xc_nxt, lnum_r, lnum_nxt, lden_r, lden_nxt;
  logic [W-1:0]    j_xc, j_rnum, j_rden, j_lnum, j_lden;
  logic [W-1:0]    rem_r, rem_nxt, den_r, den_nxt;
  logic [QW-1:0]   dvd_r, dvd_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            neg_r, neg_nxt, left_r, left_nxt, clip_r, clip_nxt;
  logic [W-1:0]    qa_r, qa_nxt, qb_r, qb_nxt, slope_r, slope_nxt, held_r, held_nxt;
  logic            out_valid_r, out_valid_nxt, out_sat_r, out_sat_nxt;
  logic            out_last_r, out_last_nxt;
  logic [W-1:0]    out_x_r, out_x_nxt, out_slope_r, out_slope_nxt;

  logic [W:0]      rsh, rdiff;
  logic            ge, over;
  logic [QW-1:0]   lim, qmag;
  logic [W-1:0]    qs;
  logic [W:0]      qsum;

  assign {job_ctl, j_xc, j_rnum, j_rden, j_lnum, j_lden} = job;
  assign pop = (state_r == S_IDLE) && !q_empty;

  // one restoring step; quotient bits shift into the dividend register
  assign rsh   = {rem_r, dvd_r[QW-1]};
  assign rdiff = rsh - {1'b0, den_r};
  assign ge    = !rdiff[W];

  assign lim  = neg_r ? LIM_NEG : LIM_POS;
  assign over = (dvd_r > lim);
  assign qmag = over ? lim : dvd_r;
  assign qs   = neg_r ? -qmag[W-1:0] : qmag[W-1:0];

  assign qsum = {qa_r[W-1], qa_r} + {qb_r[W-1], qb_r};

  always_comb begin
    state_nxt     = state_r;
    ctl_nxt       = ctl_r;
    xc_nxt        = xc_r;
    lnum_nxt      = lnum_r;
    lden_nxt      = lden_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    left_nxt      = left_r;
    clip_nxt      = clip_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    slope_nxt     = slope_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_slope_nxt = out_slope_r;
    out_sat_nxt   = out_sat_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          ctl_nxt  = job_ctl;
          xc_nxt   = j_xc;
          lnum_nxt = j_lnum;
          lden_nxt = j_lden;
          clip_nxt = 1'b0;
          rem_nxt  = '0;
          cnt_nxt  = '0;
          if (job_ctl.mode == MODE_HOLD) begin
            slope_nxt = job_ctl.set_head ? '0 : held_r;
            state_nxt = S_DONE;
          end else if (job_ctl.mode == MODE_LEFT) begin
            dvd_nxt   = {j_lnum, {FRAC_BITS{1'b0}}};
            den_nxt   = j_lden;
            neg_nxt   = job_ctl.l_neg;
            left_nxt  = 1'b1;
            state_nxt = S_DIV;
          end else begin
            dvd_nxt   = {j_rnum, {FRAC_BITS{1'b0}}};
            den_nxt   = j_rden;
            neg_nxt   = job_ctl.r_neg;
            left_nxt  = 1'b0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = ge ? rdiff[W-1:0] : rsh[W-1:0];
        dvd_nxt = {dvd_r[QW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(STEPS - 1)) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        clip_nxt = clip_r | over;
        if (ctl_r.mode == MODE_BOTH && !left_r) begin
          qa_nxt    = qs;
          dvd_nxt   = {lnum_r, {FRAC_BITS{1'b0}}};
          den_nxt   = lden_r;
          neg_nxt   = ctl_r.l_neg;
          left_nxt  = 1'b1;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else if (ctl_r.mode == MODE_BOTH) begin
          qb_nxt    = qs;
          state_nxt = S_MEAN;
        end else begin
          slope_nxt = qs;
          state_nxt = S_DONE;
        end
      end
      S_MEAN: begin
        slope_nxt = qsum[W:1];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = xc_r;
          out_slope_nxt = slope_r;
          out_sat_nxt   = clip_r;
          out_last_nxt  = ctl_r.last;
          held_nxt      = slope_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
      ctl_r       <= ctl_nxt;
      xc_r        <= xc_nxt;
      lnum_r      <= lnum_nxt;
      lden_r      <= lden_nxt;
      rem_r       <= rem_nxt;
      den_r       <= den_nxt;
      dvd_r       <= dvd_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      left_r      <= left_nxt;
      clip_r      <= clip_nxt;
      qa_r        <= qa_nxt;
      qb_r        <= qb_nxt;
      slope_r     <= slope_nxt;
      out_x_r     <= out_x_nxt;
      out_slope_r <= out_slope_nxt;
      out_sat_r   <= out_sat_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_center    = out_x_r;
  assign out_slope       = out_slope_r;
  assign out_saturated   = out_sat_r;
  assign out_last_result = out_last_r;

`ifndef SYNTHESIS
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != '0))
    else $error("divide step with zero divisor");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !pop)
    else $error("job taken while busy");
  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished word not loaded into free output register");
`endif

endmodule

// ===== rtl/nonuniform_three_point_derivative_core.sv =====
// Three-point derivative of an unevenly spaced sample stream (signed Q16.16).
// Input channel: in_valid / in_stall with x, y and set markers. A word is
// taken when in_valid is high and in_stall low. in_first_sample starts a new
// set, in_last_sample closes it. The first and last sample of a set give no
// result; every interior sample gives one word on the output channel.
// Output channel: out_valid / out_stall with the center x, the slope, a flag
// for a clipped quotient and a flag for the final word of the set.
// The front keeps the sample window and classifies each interior sample into
// a job; a two-entry job queue feeds the back, which runs a shared restoring
// divider at one quotient bit per cycle. In the back, an interior sample takes
// two quotients and their mean when both neighbours differ in x, one quotient
// with one such neighbour, and the held slope with none.
// Samples that give no result are taken at once while the queue has room.
// A stalled receiver holds the output register; the back finishes its job,
// waits, and the queue then fills until in_stall rises.
// Reset (synchronous, rst_n low) empties the window, the queue and the output.
module nonuniform_three_point_derivative_core #(
  parameter int DATA_WIDTH = nptd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_x_value,
  input  logic signed [DATA_WIDTH-1:0] in_y_value,
  input  logic                         in_first_sample,
  input  logic                         in_last_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_x_center,
  output logic signed [DATA_WIDTH-1:0] out_slope,
  output logic                         out_saturated,
  output logic                         out_last_result
);
  import nptd_pkg::*;

  localparam int JW = $bits(job_ctl_t) + JOB_WORDS * DATA_WIDTH;

  logic          q_full, q_empty, push, pop;
  logic [JW-1:0] job_in, job_out;

  nptd_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_value      (in_x_value),
    .in_y_value      (in_y_value),
    .in_first_sample (in_first_sample),
    .in_last_sample  (in_last_sample),
    .q_full          (q_full),
    .push            (push),
    .job             (job_in)
  );

  nptd_queue #(.WIDTH(JW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (job_in),
    .pop     (pop),
    .rd_data (job_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  nptd_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .job             (job_out),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_center    (out_x_center),
    .out_slope       (out_slope),
    .out_saturated   (out_saturated),
    .out_last_result (out_last_result)
  );

endmodule

// ===== bench/nonuniform_three_point_derivative_core_test.sv =====
module nonuniform_three_point_derivative_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nptd_pkg::*;

  localparam int     DW           = DATA_WIDTH_DEF;
  localparam int     CLK_PERIOD   = 10;
  localparam int     RANDOM_ITEMS = 1800;
  localparam longint SLOPE_MAX    = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint SLOPE_MIN    = -(longint'(1) <<< (DW - 1));

  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic          first;
    logic          last;
  } sample_t;

  typedef struct packed {
    logic [DW-1:0] x_center;
    logic [DW-1:0] slope;
    logic          saturated;
    logic          last_result;
  } slope_word_t;

  // CHK_MODEL: expectation comes from the predictor; the others are typed in
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_WORD} row_check_t;

  typedef struct packed {
    sample_t     smp;
    row_check_t  chk;
    slope_word_t word;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [DW-1:0] in_x_value;
  logic signed [DW-1:0] in_y_value;
  logic                 in_first_sample;
  logic                 in_last_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] out_x_center;
  logic signed [DW-1:0] out_slope;
  logic                 out_saturated;
  logic                 out_last_result;

  stim_row_t   stim_rows[$];
  slope_word_t slope_words_due[$];

  // window and held slope as the block should have them
  logic signed [DW-1:0] win_x[2];
  logic signed [DW-1:0] win_y[2];
  logic signed [DW-1:0] held_slope;
  int unsigned          fill;

  int unsigned mismatches = 0;
  int unsigned samples_taken = 0;
  int unsigned words_seen = 0;
  int unsigned clipped_words = 0;
  int unsigned held_words = 0;
  int unsigned directed_count;

  always #(CLK_PERIOD / 2) clk = ~clk;

  nonuniform_three_point_derivative_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_x_value      (in_x_value),
    .in_y_value      (in_y_value),
    .in_first_sample (in_first_sample),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_center    (out_x_center),
    .out_slope       (out_slope),
    .out_saturated   (out_saturated),
    .out_last_result (out_last_result)
  );

  // (dy * 2^16) / dx truncated toward zero, clipped to the word range
  function automatic logic [DW-1:0] q16_quotient(input logic signed [DW-1:0] y_to, y_from,
                                                 input logic signed [DW-1:0] x_to, x_from,
                                                 inout bit clipped);
    longint num, den, q;
    num = (longint'(y_to) - longint'(y_from)) <<< FRAC_BITS;
    den = longint'(x_to) - longint'(x_from);
    q = num / den;
    if (q > SLOPE_MAX) begin
      clipped = 1'b1;
      q = SLOPE_MAX;
    end else if (q < SLOPE_MIN) begin
      clipped = 1'b1;
      q = SLOPE_MIN;
    end
    return q[DW-1:0];
  endfunction

  function automatic bit derive_slope(input sample_t s, output slope_word_t w);
    logic signed [DW-1:0] xl, xc, yl, yc, qr, ql, sl;
    longint               sum;
    bit                   clipped;
    bit                   gives;
    clipped = 1'b0;
    gives = 1'b0;
    w = '0;
    if (s.first || fill == 0) begin
      win_x[0] = '0;
      win_y[0] = '0;
      win_x[1] = s.x;
      win_y[1] = s.y;
      held_slope = '0;
      fill = s.last ? 0 : 1;
      return 1'b0;
    end
    if (fill >= 2) begin
      xl = win_x[0];
      xc = win_x[1];
      yl = win_y[0];
      yc = win_y[1];
      if (s.x != xc && xl != xc) begin
        qr = q16_quotient(s.y, yc, s.x, xc, clipped);
        ql = q16_quotient(yc, yl, xc, xl, clipped);
        sum = (longint'(qr) + longint'(ql)) >>> 1;
        sl = sum[DW-1:0];
      end else if (s.x != xc) begin
        sl = q16_quotient(s.y, yc, s.x, xc, clipped);
      end else if (xl != xc) begin
        sl = q16_quotient(yc, yl, xc, xl, clipped);
      end else begin
        sl = held_slope;
        held_words++;
      end
      held_slope = sl;
      w = '{x_center: xc, slope: sl, saturated: clipped, last_result: s.last};
      gives = 1'b1;
    end
    win_x[0] = win_x[1];
    win_y[0] = win_y[1];
    win_x[1] = s.x;
    win_y[1] = s.y;
    fill = s.last ? 0 : 2;
    return gives;
  endfunction

  task automatic add_row(input logic [DW-1:0] x, y, input logic f, l, input row_check_t chk,
                         input logic [DW-1:0] xc, sl, input logic sat, lr);
    stim_row_t r;
    r.smp = '{x: x, y: y, first: f, last: l};
    r.chk = chk;
    r.word = '{x_center: xc, slope: sl, saturated: sat, last_result: lr};
    stim_rows.push_back(r);
  endtask

  // well-formed sets with random content, plus a share of short and broken ones
  task automatic add_random_set();
    int unsigned   n, style, k;
    logic [DW-1:0] x, y;
    bit            down;
    stim_row_t     r;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
    style = $urandom_range(0, 9);
    down = ($urandom_range(0, 4) == 0);
    x = $urandom;
    y = $urandom;
    for (k = 0; k < n; k++) begin
      r.chk = CHK_MODEL;
      r.word = '0;
      r.smp.first = (k == 0) && ($urandom_range(0, 15) != 0);
      r.smp.last = (k == n - 1);
      if (style <= 5) begin
        if (k > 0) begin
          if ($urandom_range(0, 5) != 0)
            x = down ? x - $urandom_range(1, 1 << 18) : x + $urandom_range(1, 1 << 18);
          y = y + $urandom_range(0, 1 << 21) - (1 << 20);
        end
      end else if (style <= 7) begin
        x = $urandom;
        y = $urandom;
      end else if (style == 8) begin
        // few distinct x values: lots of repeated neighbours and held slopes
        x = $urandom_range(0, 2) << FRAC_BITS;
        y = $urandom;
      end else begin
        x = $urandom;
        y = $urandom;
        r.smp.first = ($urandom_range(0, 3) == 0);
        r.smp.last = ($urandom_range(0, 3) == 0);
      end
      r.smp.x = x;
      r.smp.y = y;
      stim_rows.push_back(r);
    end
  endtask

  initial begin : run
    stim_row_t   r;
    slope_word_t w;
    int unsigned gap, i;
    bit          gives;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_x_value = '0;
    in_y_value = '0;
    in_first_sample = 1'b0;
    in_last_sample = 1'b0;
    win_x = '{default: '0};
    win_y = '{default: '0};
    held_slope = '0;
    fill = 0;

    //      x              y              F     L     check      x_center       slope
    add_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0002_0000, 32'h0004_0000, 1'b0, 1'b0, CHK_WORD,  32'h0001_0000, 32'h0002_0000,
            1'b0, 1'b0);
    // restart in mid-set drops the window
    add_row(32'h0008_0000, 32'h0008_0000, 1'b1, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0009_0000, 32'h0009_0000, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h000A_0000, 32'h000A_0000, 1'b0, 1'b1, CHK_WORD,  32'h0009_0000, 32'h0001_0000,
            1'b0, 1'b1);
    // one-sample set, then two-sample set
    add_row(32'h0005_0000, 32'h0005_0000, 1'b1, 1'b1, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    // both neighbours repeat x on the first derivative of a set
    add_row(32'h0007_0000, 32'h0000_0000, 1'b1, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0007_0000, 32'h0003_0000, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0007_0000, 32'h0005_0000, 1'b0, 1'b1, CHK_WORD,  32'h0007_0000, 32'h0000_0000,
            1'b0, 1'b1);
    // positive clip on a set opened without a first marker, then negative clip
    add_row(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b1, CHK_WORD,  32'h0000_0000, 32'h7FFF_FFFF,
            1'b1, 1'b1);
    add_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0000_0001, 32'h8000_0000, 1'b0, 1'b1, CHK_WORD,  32'h0000_0000, 32'h8000_0000,
            1'b1, 1'b1);
    // full-range x and y steps
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1, CHK_WORD,  32'h7FFF_FFFF, 32'h0001_0000,
            1'b0, 1'b1);
    // right neighbour repeats, then both, then left
    add_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, CHK_NONE,  '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0001_0000, 32'h0003_0000, 1'b0, 1'b0, CHK_WORD,  32'h0001_0000, 32'h0001_0000,
            1'b0, 1'b0);
    add_row(32'h0001_0000, 32'h0004_0000, 1'b0, 1'b0, CHK_WORD,  32'h0001_0000, 32'h0001_0000,
            1'b0, 1'b0);
    add_row(32'h0002_0000, 32'h0006_0000, 1'b0, 1'b1, CHK_WORD,  32'h0001_0000, 32'h0002_0000,
            1'b0, 1'b1);
    // truncation and floor of a negative mean
    add_row(32'h0001_0000, 32'h0000_0005, 1'b1, 1'b0, CHK_MODEL, '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0003_0000, 32'hFFFF_FFFA, 1'b0, 1'b0, CHK_MODEL, '0,            '0,
            1'b0, 1'b0);
    add_row(32'h0006_0000, 32'h0000_0007, 1'b0, 1'b1, CHK_MODEL, '0,            '0,
            1'b0, 1'b0);
    directed_count = stim_rows.size();

    while (stim_rows.size() < directed_count + RANDOM_ITEMS)
      add_random_set();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < stim_rows.size(); i++) begin
      r = stim_rows[i];
      // every fourth stretch of samples goes back to back
      gap = ((i / 120) % 4 == 3) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_x_value <= r.smp.x;
      in_y_value <= r.smp.y;
      in_first_sample <= r.smp.first;
      in_last_sample <= r.smp.last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      samples_taken++;
      gives = derive_slope(r.smp, w);
      case (r.chk)
        CHK_MODEL: if (gives) slope_words_due.push_back(w);
        CHK_WORD:  slope_words_due.push_back(r.word);
        CHK_NONE:  ;
        default:   ;
      endcase
    end
    in_valid <= 1'b0;

    while (slope_words_due.size() > 0) @(posedge clk);
    // let any stray word surface
    repeat (4 * DW + 80) @(posedge clk);

    $display("%0d samples taken (%0d directed), %0d slope words checked",
             samples_taken, directed_count, words_seen);
    $display("%0d words clipped, %0d slopes held over, %0d mismatches",
             clipped_words, held_words, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : drain_words
    int unsigned hold;
    slope_word_t seen, due;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (words_seen == 250)
        hold = 1500;  // long hold-off: fill the block until it stalls its input
      else if ((words_seen / 90) % 4 == 1)
        hold = 0;
      else
        hold = $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      seen = '{x_center: out_x_center, slope: out_slope,
               saturated: out_saturated, last_result: out_last_result};
      words_seen++;
      if (seen.saturated) clipped_words++;
      if (slope_words_due.size() == 0) begin
        $error("slope word with none due: x_center %0d slope %0d",
               $signed(seen.x_center), $signed(seen.slope));
        mismatches++;
      end else begin
        due = slope_words_due.pop_front();
        if (seen.x_center !== due.x_center) begin
          $error("x_center: expected %0d, got %0d",
                 $signed(due.x_center), $signed(seen.x_center));
          mismatches++;
        end
        if (seen.slope !== due.slope) begin
          $error("slope: expected %0d, got %0d", $signed(due.slope), $signed(seen.slope));
          mismatches++;
        end
        if (seen.saturated !== due.saturated) begin
          $error("saturated: expected %0b, got %0b", due.saturated, seen.saturated);
          mismatches++;
        end
        if (seen.last_result !== due.last_result) begin
          $error("last_result: expected %0b, got %0b", due.last_result, seen.last_result);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #(20_000_000);
    $error("timeout: %0d samples taken, %0d slope words still due",
           samples_taken, slope_words_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nptd_pkg.sv
rtl/nptd_front.sv
rtl/nptd_queue.sv
rtl/nptd_back.sv
rtl/nonuniform_three_point_derivative_core.sv
bench/nonuniform_three_point_derivative_core_test.sv
